@@ rtl/core/w2b_pkg.sv @@
// Shared types, codes and constants of the word-to-byte bus bridge.
`default_nettype none
package w2b_pkg;

    // Internal expansion RAM geometry.
    localparam int RAM_WORDS = 16384;
    localparam int RAM_AW    = $clog2(RAM_WORDS);

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    // Width of the queue fill plus the command still in the execute stage.
    localparam int QUEUE_SUM_W = QUEUE_CW + 1;

    // Address decode of the expansion windows (byte addresses).
    localparam logic [15:0] WIN_MASK_8K  = 16'he000;
    localparam logic [15:0] WIN_LOW      = 16'h2000;
    localparam logic [15:0] WIN_HIGH     = 16'ha000;
    localparam logic [15:0] WIN_MASK_TOP = 16'hc000;
    // Word offsets that map to RAM index zero for each window.
    localparam logic [14:0] BASE_LOW     = 15'h1000;
    localparam logic [14:0] BASE_HIGH    = 15'h4000;
    localparam logic [15:0] HIGH_BYTE    = 16'hff00;
    localparam logic [15:0] LOW_BYTE     = 16'h00ff;

    // Input action codes.
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_REPLY = 2'd2;

    // Byte lane codes.
    localparam logic [1:0] LANES_BOTH = 2'd0;
    localparam logic [1:0] LANES_HIGH = 2'd1;
    localparam logic [1:0] LANES_LOW  = 2'd2;

    // Result kind codes.
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    // Byte bus read sequence.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ODD  = 3'b010,
        PH_EVEN = 3'b100
    } t_phase;

    // Classified operation carried from the decode stage to the execute stage.
    typedef enum logic [2:0] {
        OP_RAM_RD   = 3'd0,
        OP_RAM_WR   = 3'd1,
        OP_BUS_RD   = 3'd2,
        OP_BUS_WR   = 3'd3,
        OP_ODD_RPL  = 3'd4,
        OP_EVEN_RPL = 3'd5
    } t_op;

    // One queued command; a write command expands into two beats.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [15:0] word;
        logic        two;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

endpackage
`default_nettype wire

@@ rtl/core/w2b_front.sv @@
// Front part of the bridge: decode, read sequencing, expansion RAM and prefetch bytes.
`default_nettype none
module w2b_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [1:0]                          i_action,
    input  wire logic [14:0]                         i_word_offset,
    input  wire logic [15:0]                         i_write_word,
    input  wire logic [1:0]                          i_byte_lanes,
    input  wire logic [7:0]                          i_reply_byte,
    input  wire logic                                i_reply_driven,
    input  wire logic [w2b_pkg::QUEUE_CW-1:0]        i_queue_count,
    output w2b_pkg::t_push                           o_push
);

    logic r_expansion_enable;

    w2b_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_pending, n_pending;

    logic                       r_s1_valid, n_s1_valid;
    w2b_pkg::t_op               r_s1_op, n_s1_op;
    logic [15:0]                r_s1_addr, n_s1_addr;
    logic [15:0]                r_s1_data;
    logic [1:0]                 r_s1_lanes;
    logic [7:0]                 r_s1_byte;
    logic                       r_s1_driven;
    logic [w2b_pkg::RAM_AW-1:0] r_s1_idx;
    logic                       r_s1_byp;
    logic [15:0]                r_s1_byp_data;

    logic [15:0] r_ram_q;
    logic [15:0] r_ram [w2b_pkg::RAM_WORDS];

    logic [7:0] r_pf_low, r_pf_high, r_odd_latch;

    logic                            accept;
    logic [15:0]                     addr;
    logic                            in_low, in_high, hit;
    logic [14:0]                     base;
    logic [w2b_pkg::RAM_AW-1:0]      idx;
    logic [15:0]                     merged;
    logic [15:0]                     rd_word;
    logic                            ram_we;
    logic [w2b_pkg::QUEUE_SUM_W-1:0] fill;

    // Credit: the push held in the execute stage counts toward the queue fill.
    assign fill       = w2b_pkg::QUEUE_SUM_W'(i_queue_count)
                      + w2b_pkg::QUEUE_SUM_W'(o_push.valid);
    assign o_in_ready = fill < w2b_pkg::QUEUE_SUM_W'(w2b_pkg::QUEUE_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    assign addr    = {i_word_offset, 1'b0};
    assign in_low  = (addr & w2b_pkg::WIN_MASK_8K) == w2b_pkg::WIN_LOW;
    assign in_high = ((addr & w2b_pkg::WIN_MASK_8K) == w2b_pkg::WIN_HIGH)
                  || ((addr & w2b_pkg::WIN_MASK_TOP) == w2b_pkg::WIN_MASK_TOP);
    assign hit     = r_expansion_enable && (in_low || in_high);
    assign base    = in_high ? w2b_pkg::BASE_HIGH : w2b_pkg::BASE_LOW;
    assign idx     = i_word_offset[w2b_pkg::RAM_AW-1:0] - base[w2b_pkg::RAM_AW-1:0];

    // Decode stage: classify the beat and advance the read sequence.
    always_comb begin
        n_phase    = r_phase;
        n_pending  = r_pending;
        n_s1_valid = 1'b0;
        n_s1_op    = w2b_pkg::OP_BUS_RD;
        n_s1_addr  = addr;
        if (accept) begin
            if (i_action == w2b_pkg::ACT_REPLY) begin
                case (r_phase)
                    w2b_pkg::PH_ODD: begin
                        n_phase    = w2b_pkg::PH_EVEN;
                        n_s1_valid = 1'b1;
                        n_s1_op    = w2b_pkg::OP_ODD_RPL;
                        n_s1_addr  = r_pending;
                    end
                    w2b_pkg::PH_EVEN: begin
                        n_phase    = w2b_pkg::PH_IDLE;
                        n_s1_valid = 1'b1;
                        n_s1_op    = w2b_pkg::OP_EVEN_RPL;
                    end
                    default: ;
                endcase
            end else if (r_phase == w2b_pkg::PH_IDLE) begin
                case (i_action)
                    w2b_pkg::ACT_READ: begin
                        n_s1_valid = 1'b1;
                        if (hit) begin
                            n_s1_op = w2b_pkg::OP_RAM_RD;
                        end else begin
                            n_s1_op   = w2b_pkg::OP_BUS_RD;
                            n_s1_addr = {i_word_offset, 1'b1};
                            n_pending = addr;
                            n_phase   = w2b_pkg::PH_ODD;
                        end
                    end
                    w2b_pkg::ACT_WRITE: begin
                        n_s1_valid = 1'b1;
                        n_s1_op    = hit ? w2b_pkg::OP_RAM_WR : w2b_pkg::OP_BUS_WR;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expansion_enable <= 1'b0;
            r_phase            <= w2b_pkg::PH_IDLE;
            r_pending          <= '0;
            r_s1_valid         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_expansion_enable <= i_cfg_wdata;
            end
            r_phase    <= n_phase;
            r_pending  <= n_pending;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op       <= n_s1_op;
            r_s1_addr     <= n_s1_addr;
            r_s1_data     <= i_write_word;
            r_s1_lanes    <= i_byte_lanes;
            r_s1_byte     <= i_reply_byte;
            r_s1_driven   <= i_reply_driven;
            r_s1_idx      <= idx;
            r_s1_byp      <= ram_we && (r_s1_idx == idx);
            r_s1_byp_data <= merged;
        end
    end

    // Execute stage: lane merge, RAM access and prefetch bytes.
    always_comb begin
        case (r_s1_lanes)
            w2b_pkg::LANES_HIGH: merged = (r_s1_data & w2b_pkg::HIGH_BYTE) | {8'h00, r_pf_low};
            w2b_pkg::LANES_LOW:  merged = (r_s1_data & w2b_pkg::LOW_BYTE) | {r_pf_high, 8'h00};
            default:             merged = r_s1_data;
        endcase
    end

    assign ram_we  = r_s1_valid && (r_s1_op == w2b_pkg::OP_RAM_WR);
    assign rd_word = r_s1_byp ? r_s1_byp_data : r_ram_q;

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_ram[r_s1_idx] <= merged;
        end
        r_ram_q <= r_ram[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf_low    <= '0;
            r_pf_high   <= '0;
            r_odd_latch <= '0;
        end else if (r_s1_valid) begin
            case (r_s1_op)
                w2b_pkg::OP_RAM_RD: begin
                    r_pf_low  <= rd_word[7:0];
                    r_pf_high <= rd_word[15:8];
                end
                w2b_pkg::OP_ODD_RPL: begin
                    if (r_s1_driven) begin
                        r_pf_low    <= r_s1_byte;
                        r_odd_latch <= r_s1_byte;
                    end
                end
                w2b_pkg::OP_EVEN_RPL: begin
                    if (r_s1_driven) begin
                        r_pf_high <= r_s1_byte;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_push.valid    = r_s1_valid && (r_s1_op != w2b_pkg::OP_RAM_WR);
        o_push.cmd.kind = w2b_pkg::KIND_READ;
        o_push.cmd.addr = '0;
        o_push.cmd.word = '0;
        o_push.cmd.two  = 1'b0;
        case (r_s1_op)
            w2b_pkg::OP_RAM_RD: begin
                o_push.cmd.kind = w2b_pkg::KIND_DATA;
                o_push.cmd.word = rd_word;
            end
            w2b_pkg::OP_BUS_WR: begin
                o_push.cmd.kind = w2b_pkg::KIND_WRITE;
                o_push.cmd.addr = r_s1_addr;
                o_push.cmd.word = merged;
                o_push.cmd.two  = 1'b1;
            end
            w2b_pkg::OP_EVEN_RPL: begin
                o_push.cmd.kind = w2b_pkg::KIND_DATA;
                o_push.cmd.word = {(r_s1_driven ? r_s1_byte : 8'h00), r_odd_latch};
            end
            default: begin
                o_push.cmd.addr = r_s1_addr;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/w2b_queue.sv @@
// Command queue between the front and back parts of the bridge.
`default_nettype none
module w2b_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  w2b_pkg::t_push                     i_push,
    input  wire logic                          i_pop,
    output w2b_pkg::t_cmd                      o_head,
    output logic                               o_nonempty,
    output logic [w2b_pkg::QUEUE_CW-1:0]       o_count
);

    w2b_pkg::t_cmd r_mem [w2b_pkg::QUEUE_DEPTH];
    logic [w2b_pkg::QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [w2b_pkg::QUEUE_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    assign o_head     = r_mem[r_rptr];
    assign o_nonempty = r_count != '0;
    assign o_count    = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_count < w2b_pkg::QUEUE_CW'(w2b_pkg::QUEUE_DEPTH)))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("command queue underflow");

endmodule
`default_nettype wire

@@ rtl/core/w2b_back.sv @@
// Back part of the bridge: expands queued commands into result beats.
`default_nettype none
module w2b_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  w2b_pkg::t_cmd      i_head,
    input  wire logic          i_nonempty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_bus_address,
    output logic [7:0]         o_bus_byte,
    output logic [15:0]        o_read_word,
    output logic               o_last
);

    logic        r_valid, r_second;
    logic [1:0]  r_kind;
    logic [15:0] r_addr, r_word;
    logic [7:0]  r_byte;
    logic        r_last;
    logic        load;

    assign load  = i_nonempty && (!r_valid || i_out_ready);
    assign o_pop = load && (!i_head.two || r_second);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_second <= i_head.two && !r_second;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_head.kind;
            r_word <= '0;
            r_byte <= '0;
            r_addr <= i_head.addr;
            r_last <= 1'b1;
            if (i_head.two) begin
                // Odd byte goes out first, the even byte closes the pair.
                if (r_second) begin
                    r_byte <= i_head.word[15:8];
                end else begin
                    r_addr <= {i_head.addr[15:1], 1'b1};
                    r_byte <= i_head.word[7:0];
                    r_last <= 1'b0;
                end
            end else begin
                r_word <= i_head.word;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_bus_address = r_addr;
    assign o_bus_byte    = r_byte;
    assign o_read_word   = r_word;
    assign o_last        = r_last;

    a_first_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> (r_kind == w2b_pkg::KIND_WRITE))
        else $error("non-final beat that is not a byte write");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last && i_out_ready) |=>
            (r_valid && r_last && (r_kind == w2b_pkg::KIND_WRITE)))
        else $error("second byte write beat did not follow");

endmodule
`default_nettype wire

@@ rtl/core/word_to_byte_bus_bridge_unit.sv @@
// Top level of the word-to-byte bus bridge.
// The bridge takes one input beat per cycle while o_in_ready is high: a word
// read, a word write or a reply from the byte bus. A decode stage classifies
// each beat and runs the two-reply read sequence; an execute stage merges
// byte lanes with the prefetch bytes and accesses the internal 16K-word
// expansion RAM, then places a command in a four-entry queue for every beat
// that owes a result. The back part turns each command into result beats
// through an output register; a stalled receiver holds off new input only
// once the queue has filled. Reads and replies take one result beat each and
// RAM writes take none; a byte bus write takes two beats, since it sends the
// odd byte and then the even byte, and the single output beat per cycle while
// the receiver is ready sets the rate when writes dominate. The expansion
// enable may only be changed while the bridge is idle, and RAM words read
// before being written return undefined data.
`default_nettype none
module word_to_byte_bus_bridge_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [14:0] i_word_offset,
    input  wire logic [15:0] i_write_word,
    input  wire logic [1:0]  i_byte_lanes,
    input  wire logic [7:0]  i_reply_byte,
    input  wire logic        i_reply_driven,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_bus_address,
    output logic [7:0]       o_bus_byte,
    output logic [15:0]      o_read_word,
    output logic             o_last
);

    w2b_pkg::t_push                 push;
    w2b_pkg::t_cmd                  head;
    logic                           nonempty;
    logic                           pop;
    logic [w2b_pkg::QUEUE_CW-1:0]   count;

    // Front part: decode, read sequencing, RAM and prefetch bytes.
    w2b_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_word_offset  (i_word_offset),
        .i_write_word   (i_write_word),
        .i_byte_lanes   (i_byte_lanes),
        .i_reply_byte   (i_reply_byte),
        .i_reply_driven (i_reply_driven),
        .i_queue_count  (count),
        .o_push         (push)
    );

    // The queue lets the output side stall without stopping the decode until it fills.
    w2b_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (pop),
        .o_head     (head),
        .o_nonempty (nonempty),
        .o_count    (count)
    );

    // Back part: one result beat per cycle from the queue head while the receiver is ready.
    w2b_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_nonempty    (nonempty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_bus_address (o_bus_address),
        .o_bus_byte    (o_bus_byte),
        .o_read_word   (o_read_word),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire
